### design/art_pkg.sv
// Shared types and constants for the ack/retransmit tracker.
`timescale 1ns / 1ps
package art_pkg;

    localparam int ART_PENDING_DEPTH = 16;

    localparam logic [15:0] ART_RST_INTERVAL = 16'd100;
    localparam logic [7:0]  ART_RST_LIMIT    = 8'd5;
    localparam logic [15:0] ART_RST_TIMEOUT  = 16'd1000;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_IDX_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_IDX_TIMEOUT  = 2'd2;

    // request types
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_RECV = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    // result actions
    localparam logic [2:0] ACT_SENT      = 3'd0;
    localparam logic [2:0] ACT_RETX      = 3'd1;
    localparam logic [2:0] ACT_GIVEUP    = 3'd2;
    localparam logic [2:0] ACT_ACKREPLY  = 3'd3;
    localparam logic [2:0] ACT_CLEARED   = 3'd4;
    localparam logic [2:0] ACT_UNKNOWN   = 3'd5;
    localparam logic [2:0] ACT_NOTHING   = 3'd6;
    localparam logic [2:0] ACT_UNTRACKED = 3'd7;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        ack_wanted;
        logic [15:0] retry_interval;
        logic [7:0]  retry_limit;
        logic [31:0] rx_sequence;
        logic        rx_is_ack;
        logic [31:0] acked_sequence;
    } req_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] sequence_res;
        logic [3:0]  slot;
        logic [7:0]  attempt;
        logic [31:0] peer_sequence;
        logic        alive;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [15:0] default_retry_interval;
        logic [7:0]  default_retry_limit;
        logic [15:0] alive_timeout;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_SEND,
        CMD_SEND_TRACK,
        CMD_RX_ACK,
        CMD_RX_REPLY,
        CMD_RX_PLAIN,
        CMD_TICK,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] interval;
        logic [7:0]  limit;
        logic [31:0] rx_seq;
        logic [31:0] ack_seq;
    } cmd_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] interval;
        logic [7:0]  limit;
        logic [7:0]  attempts;
        logic [15:0] elapsed;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [3:0]  slot;
        logic [7:0]  attempt;
    } pend_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_FREE,
        B_RD,
        B_EV,
        B_FLUSH
    } back_state_t;

endpackage

### design/art_front.sv
// Front end: classifies requests and queues commands for the back end.
`timescale 1ns / 1ps
module art_front
    import art_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  req_t req,
    input  logic req_valid,
    output logic req_ready,
    output cmd_t cmd,
    output logic cmd_valid,
    input  logic cmd_pop
);

    cmd_t       cls;
    cmd_t       q_mem [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    always_comb
    begin
        cls.interval = (req.retry_interval != 16'd0) ? req.retry_interval
                                                     : cfg.default_retry_interval;
        cls.limit    = (req.retry_limit != 8'd0) ? req.retry_limit
                                                 : cfg.default_retry_limit;
        cls.rx_seq   = req.rx_sequence;
        cls.ack_seq  = req.acked_sequence;
        case (req.req_type)
            REQ_SEND: cls.kind = req.ack_wanted ? CMD_SEND_TRACK : CMD_SEND;
            REQ_RECV:
            begin
                if (req.rx_is_ack)
                    cls.kind = CMD_RX_ACK;
                else if (req.ack_wanted)
                    cls.kind = CMD_RX_REPLY;
                else
                    cls.kind = CMD_RX_PLAIN;
            end
            REQ_TICK: cls.kind = CMD_TICK;
            default:  cls.kind = CMD_NOP;
        endcase
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem[rptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wptr_reg] <= cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### design/art_back.sv
// Back end: pending table walker, sequence state and result register.
`timescale 1ns / 1ps
module art_back
    import art_pkg::*;
#(
    parameter int PENDING_DEPTH = ART_PENDING_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  logic cmd_valid,
    output logic cmd_pop,
    output res_t res,
    output logic res_valid,
    input  logic res_ready
);

    localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(PENDING_DEPTH - 1);

    entry_t mem [PENDING_DEPTH];
    entry_t rdata_reg;
    logic   mem_we, rd_en;
    entry_t mem_wdata;

    back_state_t              state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [PENDING_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]              cnt_reg, cnt_next;
    logic [31:0]              peer_reg, peer_next;
    logic [31:0]              ticks_reg, ticks_next;
    pend_t                    pend_reg, pend_next;
    logic                     pend_valid_reg, pend_valid_next;
    res_t                     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic        out_free, alive;
    logic [15:0] el;
    logic [7:0]  att;
    entry_t      e;

    assign out_free  = !out_valid_reg || res_ready;
    assign alive     = ticks_reg < {16'd0, cfg.alive_timeout};
    assign res       = out_reg;
    assign res_valid = out_valid_reg;
    assign e         = rdata_reg;
    assign el        = (e.elapsed != 16'hFFFF) ? e.elapsed + 16'd1 : e.elapsed;
    assign att       = (e.attempts != 8'hFF) ? e.attempts + 8'd1 : e.attempts;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        peer_next       = peer_reg;
        ticks_next      = ticks_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        mem_wdata       = e;

        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                    case (cmd.kind)
                        CMD_SEND:
                        begin
                            cnt_next        = cnt_reg + 32'd1;
                            pend_next       = '{ACT_SENT, cnt_reg + 32'd1, 4'd0, 8'd0};
                            pend_valid_next = 1'b1;
                            state_next      = B_FLUSH;
                        end
                        CMD_SEND_TRACK:
                        begin
                            cnt_next   = cnt_reg + 32'd1;
                            state_next = B_FREE;
                        end
                        CMD_RX_ACK:
                        begin
                            peer_next  = cmd.rx_seq;
                            ticks_next = '0;
                            state_next = B_RD;
                        end
                        CMD_RX_REPLY:
                        begin
                            peer_next       = cmd.rx_seq;
                            ticks_next      = '0;
                            cnt_next        = cnt_reg + 32'd1;
                            pend_next       = '{ACT_ACKREPLY, cnt_reg + 32'd1, 4'd0, 8'd0};
                            pend_valid_next = 1'b1;
                            state_next      = B_FLUSH;
                        end
                        CMD_RX_PLAIN:
                        begin
                            peer_next       = cmd.rx_seq;
                            ticks_next      = '0;
                            pend_next       = '{ACT_NOTHING, cmd.rx_seq, 4'd0, 8'd0};
                            pend_valid_next = 1'b1;
                            state_next      = B_FLUSH;
                        end
                        CMD_TICK:
                        begin
                            if (ticks_reg != 32'hFFFF_FFFF)
                                ticks_next = ticks_reg + 32'd1;
                            state_next = B_RD;
                        end
                        default:
                            state_next = B_FLUSH;
                    endcase
                end
            end

            B_FREE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    mem_we              = 1'b1;
                    mem_wdata           = '{cnt_reg, cmd_reg.interval, cmd_reg.limit,
                                            8'd1, 16'd0};
                    valid_next[idx_reg] = 1'b1;
                    pend_next           = '{ACT_SENT, cnt_reg, 4'(idx_reg), 8'd0};
                    pend_valid_next     = 1'b1;
                    state_next          = B_FLUSH;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    pend_next       = '{ACT_UNTRACKED, cnt_reg, 4'd0, 8'd0};
                    pend_valid_next = 1'b1;
                    state_next      = B_FLUSH;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end

            B_RD:
            begin
                rd_en      = 1'b1;
                state_next = B_EV;
            end

            B_EV:
            begin
                if (cmd_reg.kind == CMD_RX_ACK)
                begin
                    if (valid_reg[idx_reg] && e.seq == cmd_reg.ack_seq)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        pend_next       = '{ACT_CLEARED, cmd_reg.ack_seq, 4'(idx_reg), 8'd0};
                        pend_valid_next = 1'b1;
                        state_next      = B_FLUSH;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        pend_next       = '{ACT_UNKNOWN, cmd_reg.ack_seq, 4'd0, 8'd0};
                        pend_valid_next = 1'b1;
                        state_next      = B_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_RD;
                    end
                end
                else if (!(valid_reg[idx_reg] && el >= e.interval
                           && pend_valid_reg && !out_free))
                begin
                    // a due entry waits here until the older held result can leave
                    if (valid_reg[idx_reg])
                    begin
                        mem_we            = 1'b1;
                        mem_wdata.elapsed = el;
                        if (el >= e.interval)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_next       = '{pend_reg.action, pend_reg.seq,
                                                   pend_reg.slot, pend_reg.attempt,
                                                   peer_reg, alive, 1'b0};
                                out_valid_next = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            if (e.attempts >= e.limit)
                            begin
                                mem_we              = 1'b0;
                                valid_next[idx_reg] = 1'b0;
                                pend_next = '{ACT_GIVEUP, e.seq, 4'(idx_reg), e.attempts};
                            end
                            else
                            begin
                                mem_wdata.attempts = att;
                                mem_wdata.elapsed  = 16'd0;
                                pend_next = '{ACT_RETX, e.seq, 4'(idx_reg), att};
                            end
                        end
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = B_FLUSH;
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_RD;
                    end
                end
            end

            B_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                        out_next = '{pend_reg.action, pend_reg.seq, pend_reg.slot,
                                     pend_reg.attempt, peer_reg, alive, 1'b1};
                    else
                        out_next = '{ACT_NOTHING, 32'd0, 4'd0, 8'd0,
                                     peer_reg, alive, 1'b1};
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = B_IDLE;
                end
            end

            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= mem_wdata;
        if (rd_en)
            rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
            peer_reg       <= '0;
            ticks_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
            peer_reg       <= peer_next;
            ticks_reg      <= ticks_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

### design/ack_retransmit_tracker.sv
// Top level of the ack/retransmit tracker.
`timescale 1ns / 1ps
// Sender-side ARQ bookkeeping for a reliable datagram link.
// Request channel (req_valid/req_ready/req): sends, receptions and 1 ms ticks.
// Result channel (res_valid/res_ready/res): one or more result transactions per
// request; the final one carries last. Config port: cfg_we writes cfg_wdata to
// register cfg_index (0 interval, 1 limit, 2 alive timeout).
// The front end classifies requests into a two-entry command queue, so
// requests keep being accepted while the back end works or the result stalls,
// until the queue is full. Plain sends and receptions pass from the queue
// through the idle and flush states into the result register.
// A tracked send scans the valid bits, one slot per cycle. An ack or tick walks
// the pending table memory slot by slot (read, then evaluate); the read is registered.
// A stalled result register holds the walker only when a second result is due.
// Reset clears all valid bits at once (no clearing pass), zeroes the counters
// and loads the register defaults.
module ack_retransmit_tracker
    import art_pkg::*;
#(
    parameter int PENDING_DEPTH = ART_PENDING_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  req_t        req,
    input  logic        req_valid,
    output logic        req_ready,
    output res_t        res,
    output logic        res_valid,
    input  logic        res_ready
);

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_valid, cmd_pop;

    // register writes, masked to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_INTERVAL: cfg_next.default_retry_interval = cfg_wdata;
                CFG_IDX_LIMIT:    cfg_next.default_retry_limit    = cfg_wdata[7:0];
                CFG_IDX_TIMEOUT:  cfg_next.alive_timeout          = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{ART_RST_INTERVAL, ART_RST_LIMIT, ART_RST_TIMEOUT};
        else
            cfg_reg <= cfg_next;
    end

    art_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    art_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

endmodule

### design/art_checker.sv
// Port-level assertions for the ack/retransmit tracker, with bind.
`timescale 1ns / 1ps
module art_checker
    import art_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input res_t res,
    input logic res_valid,
    input logic res_ready
);

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // only tick results come in groups
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.action == ACT_SENT || res.action == ACT_UNTRACKED
                      || res.action == ACT_ACKREPLY || res.action == ACT_CLEARED
                      || res.action == ACT_UNKNOWN) |-> res.last)
        else $error("single-result transaction without last");

    // a retransmit follows at least the first send
    a_retx_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.action == ACT_RETX |-> res.attempt >= 8'd2)
        else $error("retransmit with attempt below two");

    // an ACT_NOTHING result carries no slot or attempt and is last
    a_nothing_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.action == ACT_NOTHING |-> res.slot == 4'd0
                                                   && res.attempt == 8'd0 && res.last)
        else $error("idle result with slot data");

endmodule

bind ack_retransmit_tracker art_checker u_art_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
);
